// ===== hw/rtl/qrac_pkg.sv =====
// ----------------------------------------------------------------------------
// qrac_pkg
// Types, fixed-point constants and the rounding helper shared by the
// quaternion rotation angle check pipeline and its square-root unit.
// ----------------------------------------------------------------------------
package qrac_pkg;

  localparam int COEF_FRAC = 28;       // fraction bits of the internal Q28 values
  localparam int X_W       = 29;       // |w| in Q28, at most 1.0
  localparam int P_W       = 29;       // polynomial value in Q28, below 2.0
  localparam int ROOT_W    = 29;       // sqrt(1-|w|) in Q28, at most 1.0
  localparam int REM_W     = 58;       // radicand and partial remainder
  localparam int PROD_W    = 58;       // width of every Q28 by Q28 product
  localparam int RND_W     = 30;       // product rounded back to Q28
  localparam int DOT_W     = 34;       // sum of four 16x16 signed products
  localparam int ANGLE_W   = 16;
  localparam int LATENCY   = 36;       // request to result, in cycles

  localparam logic [X_W-1:0]    ONE_Q28  = 29'd268435456;
  localparam logic [PROD_W-1:0] HALF_Q28 = 58'd134217728;
  localparam logic [28:0]       C0_Q28   = 29'd421639302;
  localparam logic [25:0]       C1_Q28   = 26'd56939026;
  localparam logic [24:0]       C2_Q28   = 25'd19934285;
  localparam logic [22:0]       C3_Q28   = 23'd5027608;
  localparam logic [29:0]       PI_Q28   = 30'd843314857;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 16'd51472;
  localparam logic [ANGLE_W-1:0] LIMIT_RESET = 16'd2709;

  typedef struct packed {
    logic signed [15:0] a_w;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
  } in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] rotation_angle;
    logic               exceeds_limit;
    logic               was_clamped;
  } out_t;

  // Data that rides along the square-root pipeline.
  typedef struct packed {
    logic [P_W-1:0] p;
    logic           neg;
    logic           clamped;
  } side_t;

  // Round half up from Q56 back to Q28.
  function automatic logic [RND_W-1:0] rnd_q28(input logic [PROD_W-1:0] v);
    logic [PROD_W-1:0] sum;
    sum = v + HALF_Q28;
    return sum[COEF_FRAC +: RND_W];
  endfunction

endpackage

// ===== hw/rtl/qrac_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrac_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module qrac_sqrt import qrac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [REM_W-1:0]  in_rad,
  input  side_t             in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  logic              vld_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int B = ROOT_W - 1 - k;

    logic              pv;
    logic [REM_W-1:0]  prem;
    logic [ROOT_W-1:0] proot;
    side_t             pside;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign pv    = in_vld;
      assign prem  = in_rad;
      assign proot = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign pside = side_r[k-1];
    end

    // Setting bit B grows the square by 2*root*2^B + 2^(2B).
    assign trial = (REM_W'(proot) << (B + 1)) + (REM_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= pside;
      if (prem >= trial) begin
        rem_r[k]  <= prem - trial;
        root_r[k] <= proot | (ROOT_W'(1) << B);
      end else begin
        rem_r[k]  <= prem;
        root_r[k] <= proot;
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

// ===== hw/rtl/quaternion_rotation_angle_check.sv =====
// ----------------------------------------------------------------------------
// quaternion_rotation_angle_check
// Relative rotation angle of two Q2.14 unit quaternions, with limit check.
// ----------------------------------------------------------------------------
//  channel  ports                        direction  transfer
//  request  start, busy, in_req          in         start && !busy
//  result   out_valid, out_res           out        out_valid, one cycle
//  config   cfg_we, cfg_wdata            in         cfg_we
//
// A request is taken every cycle; busy stays low. A request passes through
// the product, dot product and polynomial stages, the 29 single-bit stages
// of the square root, then the final multiply and output stages.
// Reset (synchronous, active low) clears all valid bits and loads the limit.
// The receiver cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module quaternion_rotation_angle_check import qrac_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_t                in_req,
  output logic               out_valid,
  output out_t               out_res,
  input  logic               cfg_we,
  input  logic [ANGLE_W-1:0] cfg_wdata
);

  localparam logic signed [DOT_W-1:0] DOT_ONE   = 34'sd268435456;
  localparam logic [RND_W:0]          ROUND_Q13 = 31'd16384;

  logic [ANGLE_W-1:0] angle_limit_r;

  // Stage 1: four products.
  logic               vld1_r;
  logic signed [31:0] prod_r [4];
  // Stage 2: dot product, clamp and magnitude.
  logic               vld2_r, neg2_r, clamp2_r;
  logic [X_W-1:0]     x2_r;
  // Stages 3 to 5: Horner steps of the cubic.
  logic               vld3_r, vld4_r, vld5_r;
  logic               neg3_r, neg4_r, neg5_r;
  logic               clamp3_r, clamp4_r, clamp5_r;
  logic [X_W-1:0]     x3_r, x4_r, x5_r;
  logic [PROD_W-1:0]  m1_r, m2_r, m3_r;
  // Square root and the final two stages.
  logic               sq_vld;
  logic [ROOT_W-1:0]  sq_root;
  side_t              sq_side, sq_in_side;
  logic [REM_W-1:0]   sq_rad;
  logic               vld7_r, neg7_r, clamp7_r;
  logic [PROD_W-1:0]  pr_r;
  logic               out_valid_r;
  out_t               out_res_r;

  logic               accept;
  logic signed [DOT_W-1:0] dot, mag;
  logic [X_W-1:0]     x2_nxt;
  logic               neg2_nxt, clamp2_nxt;
  logic [RND_W-1:0]   rnd1, rnd2, rnd3, t1, t2, p6;
  logic [X_W-1:0]     v6;
  logic [RND_W-1:0]   r8, rr8;
  logic [RND_W:0]     dbl8;
  logic [ANGLE_W-1:0] angle8;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      angle_limit_r <= cfg_wdata;
    end
  end

  // Valid chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      vld4_r      <= 1'b0;
      vld5_r      <= 1'b0;
      vld7_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld1_r      <= accept;
      vld2_r      <= vld1_r;
      vld3_r      <= vld2_r;
      vld4_r      <= vld3_r;
      vld5_r      <= vld4_r;
      vld7_r      <= sq_vld;
      out_valid_r <= vld7_r;
    end
  end

  always_comb begin
    dot = DOT_W'(prod_r[0]) + DOT_W'(prod_r[1]) + DOT_W'(prod_r[2]) + DOT_W'(prod_r[3]);
    mag = dot[DOT_W-1] ? -dot : dot;
    priority if (dot > DOT_ONE) begin
      x2_nxt     = ONE_Q28;
      neg2_nxt   = 1'b0;
      clamp2_nxt = 1'b1;
    end else if (dot < -DOT_ONE) begin
      x2_nxt     = ONE_Q28;
      neg2_nxt   = 1'b1;
      clamp2_nxt = 1'b1;
    end else begin
      x2_nxt     = mag[X_W-1:0];
      neg2_nxt   = dot[DOT_W-1];
      clamp2_nxt = 1'b0;
    end
  end

  // Horner form p = c0 - x*(c1 - x*(c2 - x*c3)); every term stays positive.
  assign rnd1 = rnd_q28(m1_r);
  assign t1   = RND_W'(C2_Q28) - rnd1;
  assign rnd2 = rnd_q28(m2_r);
  assign t2   = RND_W'(C1_Q28) - rnd2;
  assign rnd3 = rnd_q28(m3_r);
  assign p6   = RND_W'(C0_Q28) - rnd3;

  assign v6         = ONE_Q28 - x5_r;
  assign sq_rad     = REM_W'({v6, COEF_FRAC'(0)});
  assign sq_in_side = '{p: p6[P_W-1:0], neg: neg5_r, clamped: clamp5_r};

  always_ff @(posedge clk) begin
    prod_r[0] <= in_req.a_w * in_req.b_w;
    prod_r[1] <= in_req.a_x * in_req.b_x;
    prod_r[2] <= in_req.a_y * in_req.b_y;
    prod_r[3] <= in_req.a_z * in_req.b_z;

    x2_r     <= x2_nxt;
    neg2_r   <= neg2_nxt;
    clamp2_r <= clamp2_nxt;

    m1_r     <= PROD_W'(C3_Q28) * PROD_W'(x2_r);
    x3_r     <= x2_r;
    neg3_r   <= neg2_r;
    clamp3_r <= clamp2_r;

    m2_r     <= PROD_W'(t1) * PROD_W'(x3_r);
    x4_r     <= x3_r;
    neg4_r   <= neg3_r;
    clamp4_r <= clamp3_r;

    m3_r     <= PROD_W'(t2) * PROD_W'(x4_r);
    x5_r     <= x4_r;
    neg5_r   <= neg4_r;
    clamp5_r <= clamp4_r;

    pr_r     <= PROD_W'(sq_side.p) * PROD_W'(sq_root);
    neg7_r   <= sq_side.neg;
    clamp7_r <= sq_side.clamped;

    out_res_r <= '{rotation_angle: angle8,
                   exceeds_limit:  angle8 > angle_limit_r,
                   was_clamped:    clamp7_r};
  end

  qrac_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld5_r),
    .in_rad   (sq_rad),
    .in_side  (sq_in_side),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // Negative dot products mirror to pi minus the value, then 2r goes to Q13.
  assign r8     = rnd_q28(pr_r);
  assign rr8    = neg7_r ? PI_Q28 - r8 : r8;
  assign dbl8   = {rr8, 1'b0} + ROUND_Q13;
  assign angle8 = dbl8[15 +: ANGLE_W];

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.rotation_angle <= ANGLE_MAX)
    else $error("rotation angle above two pi");

  a_clamp_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.was_clamped |->
      out_res_r.rotation_angle == '0 || out_res_r.rotation_angle == ANGLE_MAX)
    else $error("clamped request did not give zero or full angle");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> x2_r <= ONE_Q28 && (!neg2_r || x2_r != '0))
    else $error("dot product magnitude or sign out of range");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld |-> sq_root <= ROOT_W'(ONE_Q28))
    else $error("square root above one");

endmodule
